FILE: sv/bli_pkg.sv
`default_nettype none

package bli_pkg;

    localparam int BLI_TABLE_DEPTH = 16;
    localparam int BLI_TIME_W      = 31;
    localparam int BLI_SHIFT_W     = 16;
    localparam int BLI_ENTRY_W     = BLI_TIME_W + BLI_SHIFT_W;
    localparam int BLI_PROD_W      = BLI_TIME_W + BLI_SHIFT_W;
    localparam int BLI_QUO_W       = BLI_SHIFT_W;
    localparam int BLI_STEP_W      = $clog2(BLI_QUO_W);

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic                          opcode;
        logic [BLI_TIME_W-1:0]         event_time;
        logic signed [BLI_SHIFT_W-1:0] shift_in;
    } t_in_item;

    typedef struct packed {
        logic signed [BLI_SHIFT_W-1:0] shift_out;
        logic                          table_full;
    } t_out_item;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_ZERO,
        EMIT_FULL,
        EMIT_RD_SHIFT,
        EMIT_INTERP
    } t_emit;

    typedef struct packed {
        logic  load;
        logic  write;
        logic  idx_clr;
        logic  idx_inc;
        logic  take_prev;
        logic  prep;
        logic  mul;
        logic  div_load;
        logic  div_step;
        t_emit emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_query;
        logic empty;
        logic full;
        logic hit;
        logic idx_zero;
        logic idx_last;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: sv/bli_ram.sv
`default_nettype none

module bli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: sv/bli_ctrl.sv
`default_nettype none

module bli_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire bli_pkg::t_dp_stat i_stat,
    output bli_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy
);

    import bli_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ISSUE,
        S_CHECK,
        S_MUL,
        S_DIVLD,
        S_DIV,
        S_FIN
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [BLI_STEP_W-1:0] r_step;
    logic                  r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit = EMIT_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                if (!i_stat.is_query) begin
                    if (i_stat.full) begin
                        o_cmd.emit = EMIT_FULL;
                    end else begin
                        o_cmd.write = 1'b1;
                        o_cmd.emit  = EMIT_ZERO;
                    end
                end else if (i_stat.empty) begin
                    o_cmd.emit = EMIT_ZERO;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_ISSUE;
                end
            end
            // RAM read of the current index is in flight
            S_ISSUE: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.hit) begin
                    if (i_stat.idx_zero) begin
                        o_cmd.emit = EMIT_RD_SHIFT;
                        n_state    = S_IDLE;
                    end else begin
                        o_cmd.prep = 1'b1;
                        n_state    = S_MUL;
                    end
                end else if (i_stat.idx_last) begin
                    o_cmd.emit = EMIT_RD_SHIFT;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.take_prev = 1'b1;
                    o_cmd.idx_inc   = 1'b1;
                    n_state         = S_ISSUE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIVLD;
            end
            S_DIVLD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == BLI_STEP_W'(BLI_QUO_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.emit = EMIT_INTERP;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            if (r_state == S_DIV) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

FILE: sv/bli_dp.sv
`default_nettype none

module bli_dp #(
    parameter int TABLE_DEPTH = bli_pkg::BLI_TABLE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bli_pkg::t_in_item i_item,
    input  wire bli_pkg::t_dp_cmd  i_cmd,
    output bli_pkg::t_dp_stat      o_stat,
    output logic                   o_valid,
    output bli_pkg::t_out_item     o_result
);

    import bli_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_in_item                r_item;
    logic [CNT_W-1:0]        r_count;
    logic [IDX_W-1:0]        r_idx;
    logic [BLI_TIME_W-1:0]   r_prev_time;
    logic [BLI_SHIFT_W-1:0]  r_prev_shift;
    logic [BLI_SHIFT_W-1:0]  r_mag;
    logic                    r_neg;
    logic [BLI_TIME_W-1:0]   r_dt;
    logic [BLI_TIME_W-1:0]   r_den;
    logic [BLI_PROD_W-1:0]   r_prod;
    logic [BLI_TIME_W-1:0]   r_rem;
    logic [BLI_QUO_W-1:0]    r_q;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic [BLI_ENTRY_W-1:0]  rd_data;
    logic [BLI_TIME_W-1:0]   rd_time;
    logic [BLI_SHIFT_W-1:0]  rd_shift;
    logic [BLI_SHIFT_W:0]    diff;
    logic [BLI_SHIFT_W:0]    diff_abs;
    logic [BLI_TIME_W:0]     trial;
    logic [BLI_TIME_W:0]     trial_sub;
    logic [BLI_SHIFT_W:0]    q_signed;
    logic [BLI_SHIFT_W:0]    interp;

    bli_ram #(
        .WIDTH (BLI_ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({r_item.event_time, r_item.shift_in}),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    assign rd_time  = rd_data[BLI_ENTRY_W-1:BLI_SHIFT_W];
    assign rd_shift = rd_data[BLI_SHIFT_W-1:0];

    assign diff     = {rd_shift[BLI_SHIFT_W-1], rd_shift}
                    - {r_prev_shift[BLI_SHIFT_W-1], r_prev_shift};
    assign diff_abs = diff[BLI_SHIFT_W] ? -diff : diff;

    // restoring division, one quotient bit per step
    assign trial     = {r_rem, r_q[BLI_QUO_W-1]};
    assign trial_sub = trial - {1'b0, r_den};

    assign q_signed = r_neg ? -{1'b0, r_q} : {1'b0, r_q};
    assign interp   = {r_prev_shift[BLI_SHIFT_W-1], r_prev_shift} + q_signed;

    always_comb begin
        o_stat.is_query = (r_item.opcode == OP_QUERY);
        o_stat.empty    = (r_count == '0);
        o_stat.full     = (r_count == CNT_W'(TABLE_DEPTH));
        o_stat.hit      = (r_item.event_time < rd_time);
        o_stat.idx_zero = (r_idx == '0);
        o_stat.idx_last = ((CNT_W'(r_idx) + 1'b1) == r_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.take_prev) begin
            r_prev_time  <= rd_time;
            r_prev_shift <= rd_shift;
        end
        if (i_cmd.prep) begin
            r_mag <= diff_abs[BLI_SHIFT_W-1:0];
            r_neg <= diff[BLI_SHIFT_W];
            r_dt  <= r_item.event_time - r_prev_time;
            r_den <= rd_time - r_prev_time;
        end
        if (i_cmd.mul) begin
            r_prod <= BLI_PROD_W'(r_mag) * BLI_PROD_W'(r_dt);
        end
        // quotient stays below 2^16, so the upper product bits start below den
        if (i_cmd.div_load) begin
            r_rem <= r_prod[BLI_PROD_W-1:BLI_QUO_W];
            r_q   <= r_prod[BLI_QUO_W-1:0];
        end else if (i_cmd.div_step) begin
            if (!trial_sub[BLI_TIME_W]) begin
                r_rem <= trial_sub[BLI_TIME_W-1:0];
                r_q   <= {r_q[BLI_QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[BLI_TIME_W-1:0];
                r_q   <= {r_q[BLI_QUO_W-2:0], 1'b0};
            end
        end
        case (i_cmd.emit)
            EMIT_ZERO: begin
                r_out.shift_out  <= '0;
                r_out.table_full <= 1'b0;
            end
            EMIT_FULL: begin
                r_out.shift_out  <= '0;
                r_out.table_full <= 1'b1;
            end
            EMIT_RD_SHIFT: begin
                r_out.shift_out  <= rd_shift;
                r_out.table_full <= 1'b0;
            end
            EMIT_INTERP: begin
                r_out.shift_out  <= interp[BLI_SHIFT_W-1:0];
                r_out.table_full <= 1'b0;
            end
            default: begin
                r_out <= r_out;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.write) begin
                r_count <= r_count + 1'b1;
            end
            r_out_valid <= (i_cmd.emit != EMIT_NONE);
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

FILE: sv/breakpoint_linear_interpolator.sv
`default_nettype none

// Breakpoint table with linear interpolation between stored points.
// Input: drive i_item and raise start; the item transfers at a rising edge
// where start is high and busy is low. opcode 0 appends (event_time,
// shift_in) to the end of the table unless full; opcode 1 queries the
// shift at event_time. Output: o_valid pulses for exactly one cycle with
// o_result; every item gives exactly one result. The receiver cannot
// stall, so the result must be captured in that cycle.
// For each table entry the query scan does a registered RAM read, then a
// compare; the division yields one quotient bit per cycle (16 bits).
// busy stays high until the result cycle, so one item is in flight at a time.
// Reset clears the fill count and the output strobe; table contents are
// not cleared and only entries below the fill count are ever read.
module breakpoint_linear_interpolator #(
    parameter int TABLE_DEPTH = bli_pkg::BLI_TABLE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire bli_pkg::t_in_item i_item,
    output logic                   busy,
    output logic                   o_valid,
    output bli_pkg::t_out_item     o_result
);

    import bli_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     ctrl_busy;

    bli_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (ctrl_busy)
    );

    bli_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    assign busy = ctrl_busy;

endmodule

`default_nettype wire
